/* hw/rtl/fom_pkg.sv */
// Shared constants and types of the FIFO order matcher.
package fom_pkg;

  // Default geometry of the order books.
  localparam int unsigned BOOKS_DEF       = 256;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Order side codes.
  localparam logic [1:0] SIDE_NONE    = 2'd0;
  localparam logic [1:0] SIDE_BUY     = 2'd1;
  localparam logic [1:0] SIDE_SELL    = 2'd2;
  localparam logic [1:0] SIDE_INVALID = 2'd3;

  // Result kinds.
  typedef enum logic [1:0] {
    EV_PLACED = 2'd0,
    EV_EXEC   = 2'd1,
    EV_TICK   = 2'd2,
    EV_REJECT = 2'd3
  } ev_kind_e;

endpackage

/* hw/rtl/fom_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module fom_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/fifo_order_matcher.sv */
// Top level of the FIFO order matcher: per-instrument books and matching sequencer.
//
// Each accepted order is handled one at a time. An order that rests or is rejected
// passes through accept, book read, placed or rejected result and tick; an order
// that matches also walks the resting orders it touches, and each resting entry
// costs one read of the resting-order memory and one compare and update step.
// Ignored orders (zero quantity, side none or invalid, instrument beyond the book
// count) are only accepted and give no result. Result transactions leave through an
// output register, so a stalled sink holds the sequencer only when a new result
// is due. Book state after reset reads as empty through per-book valid bits; the
// resting-order memory needs no clearing and the block is ready right after reset.
module fifo_order_matcher
  import fom_pkg::*;
#(
  parameter int unsigned BOOKS       = BOOKS_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // instrument[7:0], order_side[9:8],
                                     // trader_id[25:10], quantity[41:26], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // event_instrument[7:0], event_trader[23:8],
                                     // event_quantity[43:24], event_side[45:44], pad
  output logic [1:0]  m_axis_tuser,  // event_kind[1:0]
  output logic        m_axis_tlast   // last
);

  localparam int unsigned BW  = (BOOKS > 1) ? $clog2(BOOKS) : 1;
  localparam int unsigned HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RD  = BOOKS * QUEUE_DEPTH;
  localparam int unsigned RAW = (RD > 1) ? $clog2(RD) : 1;
  localparam int unsigned MW  = 2 + HW + CW + 40;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_META  = 6'b000010,
    ST_MREAD = 6'b000100,
    ST_MCMP  = 6'b001000,
    ST_PLACE = 6'b010000,
    ST_TICK  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [BOOKS-1:0] bvalid_q, bvalid_d;
  logic out_valid_q, out_valid_d;

  // Current order.
  logic [7:0]  instr_q, instr_d;
  logic [1:0]  oside_q, oside_d;
  logic [15:0] trader_q, trader_d;
  logic [15:0] qty_q, qty_d;
  logic [15:0] remain_q, remain_d;
  logic        push_q, push_d;
  ev_kind_e    kind_q, kind_d;

  // Working copy of the book.
  logic [1:0]    bside_q, bside_d;
  logic [HW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [19:0]   outst_q, outst_d;
  logic [19:0]   opened_q, opened_d;

  // Output register.
  logic [1:0]  o_kind_q, o_kind_d;
  logic [7:0]  o_instr_q, o_instr_d;
  logic [15:0] o_trader_q, o_trader_d;
  logic [19:0] o_qty_q, o_qty_d;
  logic [1:0]  o_side_q, o_side_d;
  logic        o_last_q, o_last_d;

  logic [BW-1:0]  book_idx;
  logic [BW-1:0]  in_book;
  logic [7:0]     in_instr;
  logic [1:0]     in_side;
  logic [15:0]    in_trader;
  logic [15:0]    in_qty;
  logic           in_accept;
  logic           in_ignore;
  logic           out_free;

  logic           meta_we;
  logic [MW-1:0]  meta_wdata;
  logic [MW-1:0]  meta_rdata;
  logic [MW-1:0]  meta_cur;

  logic           rest_we;
  logic           rest_re;
  logic [RAW-1:0] rest_base;
  logic [RAW-1:0] rest_waddr;
  logic [RAW-1:0] rest_raddr;
  logic [31:0]    rest_wdata;
  logic [31:0]    rest_rdata;

  logic [CW:0]    slot_sum;
  logic [HW-1:0]  slot;
  logic [HW-1:0]  head_inc;
  logic [15:0]    tq;
  logic [19:0]    top_left;
  logic [15:0]    remain_new;
  logic [CW-1:0]  cnt_new;

  assign in_instr  = s_axis_tdata[7:0];
  assign in_side   = s_axis_tdata[9:8];
  assign in_trader = s_axis_tdata[25:10];
  assign in_qty    = s_axis_tdata[41:26];
  assign in_book   = in_instr[BW-1:0];
  assign book_idx  = instr_q[BW-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_ignore     = (in_qty == 16'd0) || (in_side inside {SIDE_NONE, SIDE_INVALID}) ||
                         ({1'b0, in_instr} >= 9'(BOOKS));
  assign out_free      = !out_valid_q || m_axis_tready;

  // Book state as read; a book never written reads as empty.
  assign meta_cur = bvalid_q[book_idx] ? meta_rdata : '0;

  // Resting-order addressing: book row plus slot, with modular slot arithmetic.
  assign rest_base  = RAW'(book_idx) * RAW'(QUEUE_DEPTH);
  assign slot_sum   = (CW+1)'(head_q) + (CW+1)'(cnt_q);
  assign slot       = (slot_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                      HW'(slot_sum - (CW+1)'(QUEUE_DEPTH)) : HW'(slot_sum);
  assign head_inc   = (head_q == HW'(QUEUE_DEPTH - 1)) ? '0 : head_q + HW'(1);
  assign rest_waddr = rest_base + RAW'(slot);
  assign rest_raddr = rest_base + RAW'(head_q);
  assign rest_wdata = {trader_q, qty_q};

  // Match arithmetic on the head entry.
  assign tq         = rest_rdata[15:0];
  assign top_left   = 20'({4'd0, tq} + outst_q - opened_q);
  assign remain_new = remain_q - top_left[15:0];
  assign cnt_new    = cnt_q - CW'(1);

  assign meta_wdata = {(cnt_q == '0) ? SIDE_NONE : bside_q, head_q, cnt_q, outst_q, opened_q};

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    bvalid_d    = bvalid_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    instr_d     = instr_q;
    oside_d     = oside_q;
    trader_d    = trader_q;
    qty_d       = qty_q;
    remain_d    = remain_q;
    push_d      = push_q;
    kind_d      = kind_q;
    bside_d     = bside_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    outst_d     = outst_q;
    opened_d    = opened_q;
    o_kind_d    = o_kind_q;
    o_instr_d   = o_instr_q;
    o_trader_d  = o_trader_q;
    o_qty_d     = o_qty_q;
    o_side_d    = o_side_q;
    o_last_d    = o_last_q;
    meta_we     = 1'b0;
    rest_we     = 1'b0;
    rest_re     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          instr_d  = in_instr;
          oside_d  = in_side;
          trader_d = in_trader;
          qty_d    = in_qty;
          if (!in_ignore) begin
            state_d = ST_META;
          end
        end
      end

      ST_META: begin
        {bside_d, head_d, cnt_d, outst_d, opened_d} = meta_cur;
        remain_d = qty_q;
        if ((meta_cur[MW-3-HW -: CW] == '0) || (oside_q == meta_cur[MW-1 -: 2])) begin
          push_d  = (meta_cur[MW-3-HW -: CW] < CW'(QUEUE_DEPTH));
          kind_d  = push_d ? EV_PLACED : EV_REJECT;
          state_d = ST_PLACE;
        end else begin
          state_d = ST_MREAD;
        end
      end

      ST_MREAD: begin
        rest_re = 1'b1;
        state_d = ST_MCMP;
      end

      ST_MCMP: begin
        if (top_left > {4'd0, remain_q}) begin
          // Partial fill of the head order ends the walk.
          outst_d  = outst_q - {4'd0, remain_q};
          remain_d = '0;
          kind_d   = EV_EXEC;
          push_d   = 1'b0;
          state_d  = ST_PLACE;
        end else if (out_free) begin
          // Head order fully filled: it leaves the queue.
          out_valid_d = 1'b1;
          o_kind_d    = EV_EXEC;
          o_instr_d   = instr_q;
          o_trader_d  = rest_rdata[31:16];
          o_qty_d     = {4'd0, tq};
          o_side_d    = bside_q;
          o_last_d    = 1'b0;
          remain_d    = remain_new;
          head_d      = head_inc;
          cnt_d       = cnt_new;
          outst_d     = outst_q - top_left;
          opened_d    = opened_q - {4'd0, tq};
          if (remain_new == '0) begin
            kind_d  = EV_EXEC;
            push_d  = 1'b0;
            state_d = ST_PLACE;
          end else if (cnt_new == '0) begin
            kind_d  = EV_PLACED;
            push_d  = 1'b1;
            state_d = ST_PLACE;
          end else begin
            state_d = ST_MREAD;
          end
        end
      end

      ST_PLACE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_kind_d    = kind_q;
          o_instr_d   = instr_q;
          o_trader_d  = trader_q;
          o_qty_d     = {4'd0, qty_q};
          o_side_d    = oside_q;
          o_last_d    = 1'b0;
          if (push_q) begin
            rest_we  = 1'b1;
            cnt_d    = cnt_q + CW'(1);
            bside_d  = oside_q;
            outst_d  = outst_q + {4'd0, remain_q};
            opened_d = opened_q + {4'd0, qty_q};
          end
          state_d = ST_TICK;
        end
      end

      ST_TICK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_kind_d    = EV_TICK;
          o_instr_d   = instr_q;
          o_trader_d  = '0;
          o_qty_d     = (cnt_q == '0) ? '0 : outst_q;
          o_side_d    = (cnt_q == '0) ? SIDE_NONE : bside_q;
          o_last_d    = 1'b1;
          meta_we     = 1'b1;
          bvalid_d[book_idx] = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bvalid_q    <= bvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    instr_q    <= instr_d;
    oside_q    <= oside_d;
    trader_q   <= trader_d;
    qty_q      <= qty_d;
    remain_q   <= remain_d;
    push_q     <= push_d;
    kind_q     <= kind_d;
    bside_q    <= bside_d;
    head_q     <= head_d;
    cnt_q      <= cnt_d;
    outst_q    <= outst_d;
    opened_q   <= opened_d;
    o_kind_q   <= o_kind_d;
    o_instr_q  <= o_instr_d;
    o_trader_q <= o_trader_d;
    o_qty_q    <= o_qty_d;
    o_side_q   <= o_side_d;
    o_last_q   <= o_last_d;
  end

  // Per-book state: side, head, count, outstanding and opened totals.
  fom_ram #(
    .WIDTH(MW),
    .DEPTH(BOOKS)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(book_idx),
    .wdata_i(meta_wdata),
    .re_i   (in_accept),
    .raddr_i(in_book),
    .rdata_o(meta_rdata)
  );

  // Resting orders: trader in the upper half, original quantity in the lower half.
  fom_ram #(
    .WIDTH(32),
    .DEPTH(RD)
  ) u_rest_ram (
    .clk_i  (clk_i),
    .we_i   (rest_we),
    .waddr_i(rest_waddr),
    .wdata_i(rest_wdata),
    .re_i   (rest_re),
    .raddr_i(rest_raddr),
    .rdata_o(rest_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {2'd0, o_side_q, o_qty_q, o_trader_q, o_instr_q};

  // The tick and only the tick closes the results of an order.
  a_tick_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == EV_TICK)))
    else $error("tlast does not coincide with a tick result");

  // The matching walk only runs on a non-empty book.
  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MREAD || state_q == ST_MCMP) |-> (cnt_q != '0))
    else $error("matching walk on an empty book");

  // A push never overfills the queue.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rest_we |-> (cnt_q < CW'(QUEUE_DEPTH)))
    else $error("push into a full queue");

  // Book state is written back only when the tick goes out.
  a_meta_with_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta_we |=> (m_axis_tvalid && m_axis_tlast))
    else $error("book write-back without a tick result");

endmodule

/* tb/fifo_order_matcher_test.sv */
// Self-checking testbench of the FIFO order matcher: predicted events versus stream output.
module fifo_order_matcher_test
  import fom_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBOOK = BOOKS_DEF;
  localparam int unsigned QDEPTH = QUEUE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One book event as it leaves the block.
  typedef struct packed {
    ev_kind_e    kind;
    logic [7:0]  instr;
    logic [15:0] trader;
    logic [19:0] qty;
    logic [1:0]  side;
    logic        last;
  } book_event_t;

  // Scoreboard: a model of all books plus the queue of events still due.
  class order_book_board;
    logic [1:0]  side_of[NBOOK];
    logic [31:0] slots[NBOOK][QDEPTH];
    int unsigned head[NBOOK];
    int unsigned count[NBOOK];
    logic [19:0] outstanding[NBOOK];
    logic [19:0] opened[NBOOK];
    book_event_t pending_events[$];
    int unsigned mismatches;
    int unsigned events_seen;
    int unsigned orders_seen;
    int unsigned fills_seen;
    int unsigned rejects_seen;

    function new();
      for (int b = 0; b < NBOOK; b++) begin
        side_of[b] = SIDE_NONE;
        head[b] = 0;
        count[b] = 0;
        outstanding[b] = '0;
        opened[b] = '0;
      end
      mismatches = 0;
      events_seen = 0;
      orders_seen = 0;
      fills_seen = 0;
      rejects_seen = 0;
    endfunction

    function void push_event(ev_kind_e k, logic [7:0] i, logic [15:0] t,
                             logic [19:0] q, logic [1:0] s);
      book_event_t e;
      e.kind = k;
      e.instr = i;
      e.trader = t;
      e.qty = q;
      e.side = s;
      e.last = 1'b0;
      pending_events.push_back(e);
    endfunction

    // Apply one accepted order to the books and queue its events.
    function void note_order(logic [7:0] instr, logic [1:0] side,
                             logic [15:0] trader, logic [15:0] qty);
      logic [19:0] remain;
      logic [19:0] top_left;
      logic [31:0] entry;
      int unsigned b;
      b = instr;
      if (qty == 0 || (side inside {SIDE_NONE, SIDE_INVALID})) return;
      orders_seen++;
      if (count[b] == 0 || side == side_of[b]) begin
        if (count[b] >= QDEPTH) begin
          push_event(EV_REJECT, instr, trader, 20'(qty), side);
          rejects_seen++;
        end else begin
          slots[b][(head[b] + count[b]) % QDEPTH] = {trader, qty};
          count[b]++;
          side_of[b] = side;
          outstanding[b] += 20'(qty);
          opened[b] += 20'(qty);
          push_event(EV_PLACED, instr, trader, 20'(qty), side);
        end
      end else begin
        remain = 20'(qty);
        while (count[b] != 0 && remain != 0) begin
          entry = slots[b][head[b]];
          top_left = 20'(entry[15:0]) + outstanding[b] - opened[b];
          if (top_left > remain) begin
            outstanding[b] -= remain;
            remain = 0;
          end else begin
            remain -= top_left;
            head[b] = (head[b] + 1) % QDEPTH;
            count[b]--;
            outstanding[b] -= top_left;
            opened[b] -= 20'(entry[15:0]);
            push_event(EV_EXEC, instr, entry[31:16], 20'(entry[15:0]), side_of[b]);
            fills_seen++;
          end
        end
        if (remain == 0) begin
          push_event(EV_EXEC, instr, trader, 20'(qty), side);
        end else begin
          slots[b][(head[b] + count[b]) % QDEPTH] = {trader, qty};
          count[b]++;
          side_of[b] = side;
          outstanding[b] += remain;
          opened[b] += 20'(qty);
          push_event(EV_PLACED, instr, trader, 20'(qty), side);
        end
      end
      if (count[b] == 0) begin
        side_of[b] = SIDE_NONE;
        push_event(EV_TICK, instr, '0, '0, SIDE_NONE);
      end else begin
        push_event(EV_TICK, instr, '0, outstanding[b], side_of[b]);
      end
      pending_events[$].last = 1'b1;
    endfunction

    // Compare one output transaction with the oldest pending event.
    function void check_event(book_event_t got);
      book_event_t want;
      events_seen++;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event: kind %0d instr %0d trader %0d qty %0d side %0d",
                   got.kind, got.instr, got.trader, got.qty, got.side);
        return;
      end
      want = pending_events[0];
      pending_events.delete(0);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"event mismatch: expected k%0d i%0d t%0d q%0d s%0d l%0d,",
                    " got k%0d i%0d t%0d q%0d s%0d l%0d"},
                   want.kind, want.instr, want.trader, want.qty, want.side, want.last,
                   got.kind, got.instr, got.trader, got.qty, got.side, got.last);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  order_book_board board;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  bit          hold_sink;
  int unsigned cycle_count;

  fifo_order_matcher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Cycle limit as a watchdog.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Sink: random stalls, and a long hold-off when requested.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni)
        m_axis_tready <= !hold_sink && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Monitor of output transactions.
  initial begin
    book_event_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.kind = ev_kind_e'(m_axis_tuser);
        got.instr = m_axis_tdata[7:0];
        got.trader = m_axis_tdata[23:8];
        got.qty = m_axis_tdata[43:24];
        got.side = m_axis_tdata[45:44];
        got.last = m_axis_tlast;
        board.check_event(got);
      end
    end
  end

  // Offer one order and wait until it is accepted; idle gaps come first.
  task automatic send_order(logic [7:0] instr, logic [1:0] side,
                            logic [15:0] trader, logic [15:0] qty);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, qty, trader, side, instr};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_order(instr, side, trader, qty);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
  endtask

  // A random order, mostly well-formed and mostly on a few hot books.
  task automatic send_random_order();
    logic [7:0]  instr;
    logic [1:0]  side;
    logic [15:0] qty;
    int unsigned pick;
    pick = $urandom_range(99);
    instr = (pick < 85) ? 8'($urandom_range(3)) : 8'($urandom);
    side = ($urandom_range(1)) ? SIDE_BUY : SIDE_SELL;
    if (pick < 5) side = 2'($urandom_range(3));
    case ($urandom_range(3))
      0: qty = 16'($urandom);
      1: qty = 16'($urandom_range(1, 8));
      default: qty = 16'($urandom_range(0, 40));
    endcase
    send_order(instr, side, 16'($urandom), qty);
  endtask

  task automatic drain();
    while (board.pending_events.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    board = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_sink = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ignored orders, extreme fields, rest, partial and full fills.
    send_order(8'd5, SIDE_NONE, 16'hffff, 16'd10);
    send_order(8'd5, SIDE_INVALID, 16'h1234, 16'd10);
    send_order(8'd5, SIDE_BUY, 16'h1234, 16'd0);
    send_order(8'd255, SIDE_SELL, 16'hffff, 16'hffff);
    send_order(8'd255, SIDE_SELL, 16'h0000, 16'hffff);
    send_order(8'd255, SIDE_BUY, 16'h5555, 16'd1);
    send_order(8'd255, SIDE_BUY, 16'haaaa, 16'hfffe);
    send_order(8'd255, SIDE_BUY, 16'h0001, 16'hffff);
    send_order(8'd0, SIDE_BUY, 16'd7, 16'd5);
    send_order(8'd0, SIDE_BUY, 16'd8, 16'd6);
    send_order(8'd0, SIDE_SELL, 16'd9, 16'd11);
    send_order(8'd0, SIDE_SELL, 16'd10, 16'd3);
    send_order(8'd0, SIDE_BUY, 16'd11, 16'd9);
    // Fill one book to overflow, then sweep it.
    for (int k = 0; k < QDEPTH + 2; k++)
      send_order(8'd1, SIDE_SELL, 16'(100 + k), 16'd1);
    send_order(8'd1, SIDE_BUY, 16'd200, 16'd40);
    end_burst();
    drain();

    // Random phases with various idle and stall mixes.
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 22 : 68) : 0;
      sink_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 22 : 68) : 0;
      for (int n = 0; n < 70; n++) send_random_order();
      end_burst();
      drain();
    end

    // Long sink hold-off while orders keep coming, so the block backs up.
    src_idle_pct = 0;
    sink_stall_pct = 0;
    fork
      begin
        hold_sink = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      begin
        for (int n = 0; n < 20; n++) send_random_order();
        end_burst();
      end
    join
    drain();

    $display("ran %0d orders: %0d events checked, %0d resting fills, %0d rejects",
             board.orders_seen, board.events_seen, board.fills_seen, board.rejects_seen);
    if (board.mismatches == 0 && board.pending_events.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d events missing", board.mismatches,
               board.pending_events.size());
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
